@@ src/twsp_pkg.sv @@
// shared constants and helpers for the three-wire serial panel master
package twsp_pkg;

   localparam int unsigned DelayWidth = 8;
   localparam int unsigned ShiftWidth = 24;
   localparam int unsigned CountWidth = 5;
   localparam int unsigned CsrIndexWidth = 2;

   typedef logic [DelayWidth-1:0] delay_type;
   typedef logic [CountWidth-1:0] count_type;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_BIT  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FRAME_GAP = 2'd1;

   // transfer modes
   localparam logic [1:0] MODE_NINE_BIT  = 2'd0;
   localparam logic [1:0] MODE_START_BYTE = 2'd1;
   localparam logic [1:0] MODE_START_WORD = 2'd2;
   localparam logic [1:0] MODE_START_READ = 2'd3;

   // bit counts per mode
   localparam count_type BITS_NINE = 5'd9;
   localparam count_type BITS_BYTE = 5'd16;
   localparam count_type BITS_WORD = 5'd24;
   localparam count_type BITS_READ = 5'd8;

   localparam delay_type HALF_BIT_RESET  = 8'd1;
   localparam delay_type FRAME_GAP_RESET = 8'd5;

   // a step held d ticks waits d-1 more ticks; zero acts as one
   function automatic delay_type hold_count(input delay_type d);
      hold_count = (d == '0) ? '0 : d - 8'd1;
   endfunction

endpackage

@@ src/three_wire_serial_panel_master.sv @@
// three-wire serial panel master: line sequencer advanced one tick per item
//
// usage: every req item is one timing tick. an idle tick with req_start_req
// set starts a frame: select high, clock high, select low, the bits msb first
// (clock low, data set or line sampled, clock high), a gap, select high.
// req_mode picks nine-bit, start+byte, start+word or start+read framing.
// each tick item yields exactly one rsp item with the line levels, busy,
// done and the receive shift register after that tick.
// rsp valid is registered: it rises in the cycle after req accept.
// throughput: one item per cycle when not stalled; the tick update is one pass
// of logic between the sequencer registers and the rsp output register.
// stall: req_ready drops only while a result sits unread in the output
// register with rsp_ready low; the sequencer advances only on accepted items.
// reset: synchronous, active high; sequencer idle, select high, clock low,
// data low, driving, half-bit delay 1 tick, frame gap 5 ticks.
// csr port: write half_bit_ticks (index 0) or frame_gap_ticks (index 1)
// with csr_write_enable; other indexes are ignored.
module three_wire_serial_panel_master
   import twsp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_start_req,
   input  logic [1:0]               req_mode,
   input  logic [7:0]               req_start_code,
   input  logic [15:0]              req_payload,
   input  logic                     req_line_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_chip_select,
   output logic                     rsp_serial_clock,
   output logic                     rsp_line_out,
   output logic                     rsp_line_drive,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [7:0]               rsp_read_byte,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [DelayWidth-1:0]    csr_write_data
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SEL_HIGH, PH_CLK_HIGH, PH_SEL_LOW,
      PH_BIT_LOW, PH_BIT_DATA, PH_BIT_HIGH, PH_GAP
   } phase_type;

   // config registers
   delay_type half_bit_ff, frame_gap_ff;

   // sequencer state
   phase_type             phase_ff, phase_in;
   delay_type             wait_count_ff, wait_count_in;
   count_type             bits_left_ff, bits_left_in;
   logic [ShiftWidth-1:0] send_shift_ff, send_shift_in;
   logic [7:0]            receive_shift_ff, receive_shift_in;
   logic [1:0]            active_mode_ff, active_mode_in;
   logic                  cs_ff, cs_in;
   logic                  clk_ff, clk_in;
   logic                  data_ff, data_in;
   logic                  drive_ff, drive_in;
   logic                  done_in;

   // output register
   logic                  rsp_valid_ff;
   logic                  done_ff;
   logic                  busy_ff;

   logic      accept;
   count_type bits_dec;
   logic      read_bit_now;
   logic      read_bit_next;

   // a result may be replaced as soon as it is being taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign bits_dec      = (bits_left_ff != '0) ? bits_left_ff - 5'd1 : bits_left_ff;
   assign read_bit_now  = (active_mode_ff == MODE_START_READ) && (bits_left_ff <= BITS_READ);
   assign read_bit_next = (active_mode_ff == MODE_START_READ) && (bits_dec <= BITS_READ);

   // one tick of the line sequencer
   always_comb begin
      phase_in         = phase_ff;
      wait_count_in    = wait_count_ff;
      bits_left_in     = bits_left_ff;
      send_shift_in    = send_shift_ff;
      receive_shift_in = receive_shift_ff;
      active_mode_in   = active_mode_ff;
      cs_in            = cs_ff;
      clk_in           = clk_ff;
      data_in          = data_ff;
      drive_in         = drive_ff;
      done_in          = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (req_start_req) begin
            active_mode_in = req_mode;
            case (req_mode)
               MODE_NINE_BIT: begin
                  send_shift_in = {req_start_code[0], req_payload[7:0], 15'd0};
                  bits_left_in  = BITS_NINE;
               end
               MODE_START_BYTE: begin
                  send_shift_in = {req_start_code, req_payload[7:0], 8'd0};
                  bits_left_in  = BITS_BYTE;
               end
               MODE_START_WORD: begin
                  send_shift_in = {req_start_code, req_payload};
                  bits_left_in  = BITS_WORD;
               end
               default: begin
                  send_shift_in = {req_start_code, 16'd0};
                  bits_left_in  = BITS_BYTE;
               end
            endcase
            cs_in         = 1'b1;
            phase_in      = PH_SEL_HIGH;
            wait_count_in = hold_count(frame_gap_ff);
         end
      end else if (wait_count_ff != '0) begin
         wait_count_in = wait_count_ff - 8'd1;
      end else begin
         case (phase_ff)
            PH_SEL_HIGH: begin
               clk_in        = 1'b1;
               phase_in      = PH_CLK_HIGH;
               wait_count_in = hold_count(frame_gap_ff);
            end
            PH_CLK_HIGH: begin
               cs_in         = 1'b0;
               phase_in      = PH_SEL_LOW;
               wait_count_in = hold_count(frame_gap_ff);
            end
            PH_SEL_LOW: begin
               clk_in = 1'b0;
               if (read_bit_now) begin
                  drive_in = 1'b0;
               end
               phase_in      = PH_BIT_LOW;
               wait_count_in = hold_count(half_bit_ff);
            end
            PH_BIT_LOW: begin
               if (read_bit_now) begin
                  receive_shift_in = {receive_shift_ff[6:0], req_line_in};
               end else begin
                  data_in       = send_shift_ff[ShiftWidth-1];
                  send_shift_in = {send_shift_ff[ShiftWidth-2:0], 1'b0};
               end
               phase_in      = PH_BIT_DATA;
               wait_count_in = hold_count(half_bit_ff);
            end
            PH_BIT_DATA: begin
               clk_in        = 1'b1;
               phase_in      = PH_BIT_HIGH;
               wait_count_in = hold_count(half_bit_ff);
            end
            PH_BIT_HIGH: begin
               bits_left_in = bits_dec;
               if (bits_dec != '0) begin
                  // next bit: clock falls, line released on read bits
                  clk_in = 1'b0;
                  if (read_bit_next) begin
                     drive_in = 1'b0;
                  end
                  phase_in      = PH_BIT_LOW;
                  wait_count_in = hold_count(half_bit_ff);
               end else begin
                  drive_in      = 1'b1;
                  phase_in      = PH_GAP;
                  wait_count_in = hold_count(frame_gap_ff);
               end
            end
            PH_GAP: begin
               cs_in    = 1'b1;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // sequencer state, config and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ff      <= HALF_BIT_RESET;
         frame_gap_ff     <= FRAME_GAP_RESET;
         phase_ff         <= PH_IDLE;
         wait_count_ff    <= '0;
         bits_left_ff     <= '0;
         send_shift_ff    <= '0;
         receive_shift_ff <= '0;
         active_mode_ff   <= '0;
         cs_ff            <= 1'b1;
         clk_ff           <= 1'b0;
         data_ff          <= 1'b0;
         drive_ff         <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         done_ff          <= 1'b0;
         busy_ff          <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HALF_BIT:  half_bit_ff  <= csr_write_data;
               CSR_FRAME_GAP: frame_gap_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff         <= phase_in;
            wait_count_ff    <= wait_count_in;
            bits_left_ff     <= bits_left_in;
            send_shift_ff    <= send_shift_in;
            receive_shift_ff <= receive_shift_in;
            active_mode_ff   <= active_mode_in;
            cs_ff            <= cs_in;
            clk_ff           <= clk_in;
            data_ff          <= data_in;
            drive_ff         <= drive_in;
            done_ff          <= done_in;
            busy_ff          <= (phase_in != PH_IDLE);
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // the sequencer registers double as the rsp payload
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chip_select  = cs_ff;
   assign rsp_serial_clock = clk_ff;
   assign rsp_line_out     = data_ff;
   assign rsp_line_drive   = drive_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_read_byte    = receive_shift_ff;

endmodule

@@ bench/tb_three_wire_serial_panel_master.sv @@
// testbench for the three-wire serial panel master: directed frames, then random ticks
`timescale 1ns / 100ps

module tb_three_wire_serial_panel_master;
   import twsp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned BREAK_PCT   = 32;
   localparam int unsigned REPORT_MAX  = 10;
   localparam int unsigned REQ_PCT     = 25;

   // indexes past the two registers, a write there must change nothing
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_B = 2'd3;

   // level of the shared line while the block listens
   localparam int LINE_LOW    = 0;
   localparam int LINE_HIGH   = 1;
   localparam int LINE_RANDOM = 2;

   // sequencer steps of one frame
   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_SEL_HIGH, SEQ_CLK_HIGH, SEQ_SEL_LOW,
      SEQ_BIT_LOW, SEQ_BIT_DATA, SEQ_BIT_HIGH, SEQ_GAP
   } seq_phase_type;

   // one tick item as it goes into the block
   typedef struct packed {
      logic        start_req;
      logic [1:0]  mode;
      logic [7:0]  start_code;
      logic [15:0] payload;
      logic        line_in;
   } tick_item_type;

   // line levels and status after one tick
   typedef struct packed {
      logic       sel;
      logic       sclk;
      logic       dout;
      logic       drive;
      logic       busy;
      logic       done;
      logic [7:0] rx;
   } line_levels_type;

   // tracks the line sequencer tick by tick and holds the levels still owed
   class line_tracker_type;
      delay_type             half_bit;
      delay_type             frame_gap;
      seq_phase_type         phase;
      delay_type             ticks_left;
      count_type             bits_left;
      logic [ShiftWidth-1:0] tx_shift;
      logic [7:0]            rx_shift;
      logic [1:0]            frame_mode;
      logic                  sel, sclk, dout, drive;
      line_levels_type       pending_levels[$];
      int unsigned           mismatches;

      function new();
         half_bit   = HALF_BIT_RESET;
         frame_gap  = FRAME_GAP_RESET;
         phase      = SEQ_IDLE;
         ticks_left = '0;
         bits_left  = '0;
         tx_shift   = '0;
         rx_shift   = '0;
         frame_mode = MODE_NINE_BIT;
         sel        = 1'b1;
         sclk       = 1'b0;
         dout       = 1'b0;
         drive      = 1'b1;
         mismatches = 0;
      endfunction

      function void write_reg(input logic [CsrIndexWidth-1:0] index, input delay_type value);
         if (index == CSR_HALF_BIT)
            half_bit = value;
         else if (index == CSR_FRAME_GAP)
            frame_gap = value;
      endfunction

      function bit frame_active();
         return phase != SEQ_IDLE;
      endfunction

      // a step held d ticks waits d-1 more, zero counts as one
      function void hold_for(input delay_type d);
         ticks_left = (d > 8'd1) ? d - 8'd1 : '0;
      endfunction

      // the last eight bits of a read frame are sampled, not sent
      function bit reading();
         return frame_mode == MODE_START_READ && bits_left <= BITS_READ;
      endfunction

      function void clock_fall();
         sclk = 1'b0;
         if (reading())
            drive = 1'b0;
         phase = SEQ_BIT_LOW;
         hold_for(half_bit);
      endfunction

      function void take_tick(input tick_item_type t);
         line_levels_type want;
         logic            done;
         done = 1'b0;
         if (phase == SEQ_IDLE) begin
            if (t.start_req) begin
               frame_mode = t.mode;
               case (t.mode)
                  MODE_NINE_BIT: begin
                     tx_shift  = {t.start_code[0], t.payload[7:0], 15'd0};
                     bits_left = BITS_NINE;
                  end
                  MODE_START_BYTE: begin
                     tx_shift  = {t.start_code, t.payload[7:0], 8'd0};
                     bits_left = BITS_BYTE;
                  end
                  MODE_START_WORD: begin
                     tx_shift  = {t.start_code, t.payload};
                     bits_left = BITS_WORD;
                  end
                  default: begin
                     tx_shift  = {t.start_code, 16'd0};
                     bits_left = BITS_BYTE;
                  end
               endcase
               sel   = 1'b1;
               phase = SEQ_SEL_HIGH;
               hold_for(frame_gap);
            end
         end else if (ticks_left != '0) begin
            ticks_left--;
         end else begin
            case (phase)
               SEQ_SEL_HIGH: begin
                  sclk  = 1'b1;
                  phase = SEQ_CLK_HIGH;
                  hold_for(frame_gap);
               end
               SEQ_CLK_HIGH: begin
                  sel   = 1'b0;
                  phase = SEQ_SEL_LOW;
                  hold_for(frame_gap);
               end
               SEQ_SEL_LOW: clock_fall();
               SEQ_BIT_LOW: begin
                  if (reading()) begin
                     rx_shift = {rx_shift[6:0], t.line_in};
                  end else begin
                     dout     = tx_shift[ShiftWidth-1];
                     tx_shift = tx_shift << 1;
                  end
                  phase = SEQ_BIT_DATA;
                  hold_for(half_bit);
               end
               SEQ_BIT_DATA: begin
                  sclk  = 1'b1;
                  phase = SEQ_BIT_HIGH;
                  hold_for(half_bit);
               end
               SEQ_BIT_HIGH: begin
                  if (bits_left != '0)
                     bits_left--;
                  if (bits_left != '0) begin
                     clock_fall();
                  end else begin
                     drive = 1'b1;
                     phase = SEQ_GAP;
                     hold_for(frame_gap);
                  end
               end
               SEQ_GAP: begin
                  sel   = 1'b1;
                  phase = SEQ_IDLE;
                  done  = 1'b1;
               end
               default: phase = SEQ_IDLE;
            endcase
         end
         want = '{sel, sclk, dout, drive, phase != SEQ_IDLE, done, rx_shift};
         pending_levels.push_back(want);
      endfunction

      function string show(input line_levels_type l);
         return $sformatf("cs %b clk %b data %b drive %b busy %b done %b read %02h",
                          l.sel, l.sclk, l.dout, l.drive, l.busy, l.done, l.rx);
      endfunction

      function void note_mismatch(input string msg);
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("%0t mismatch: %s", $time, msg);
      endfunction

      function void check_levels(input line_levels_type got);
         line_levels_type want;
         if (pending_levels.size() == 0) begin
            note_mismatch({"result with no item waiting: ", show(got)});
            return;
         end
         want = pending_levels.pop_front();
         if (got.sel !== want.sel || got.sclk !== want.sclk || got.dout !== want.dout ||
             got.drive !== want.drive || got.busy !== want.busy ||
             got.done !== want.done || got.rx !== want.rx)
            note_mismatch({"expected ", show(want), ", got ", show(got)});
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_start_req;
   logic [1:0]               req_mode;
   logic [7:0]               req_start_code;
   logic [15:0]              req_payload;
   logic                     req_line_in;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_chip_select;
   logic                     rsp_serial_clock;
   logic                     rsp_line_out;
   logic                     rsp_line_drive;
   logic                     rsp_busy_res;
   logic                     rsp_done_res;
   logic [7:0]               rsp_read_byte;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [DelayWidth-1:0]    csr_write_data;

   line_levels_type     rsp_levels;
   line_tracker_type    tracker = new();
   bit                  steady_flow = 1'b0;
   int unsigned         cycle_count = 0;

   three_wire_serial_panel_master DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_req    (req_start_req),
      .req_mode         (req_mode),
      .req_start_code   (req_start_code),
      .req_payload      (req_payload),
      .req_line_in      (req_line_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chip_select  (rsp_chip_select),
      .rsp_serial_clock (rsp_serial_clock),
      .rsp_line_out     (rsp_line_out),
      .rsp_line_drive   (rsp_line_drive),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_byte    (rsp_read_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   assign rsp_levels = {rsp_chip_select, rsp_serial_clock, rsp_line_out, rsp_line_drive,
                        rsp_busy_res, rsp_done_res, rsp_read_byte};

   // roughly a third of the cycles idle unless a steady stretch is running
   function automatic bit take_break();
      return !steady_flow && ($urandom_range(0, 99) < BREAK_PCT);
   endfunction

   // receiver: ready changes on the falling edge
   always @(negedge clock) begin
      rsp_ready <= !take_break();
   end

   // every accepted result goes against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_levels(rsp_levels);
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL three_wire_serial_panel_master");
         $finish;
      end
   end

   function automatic tick_item_type random_tick(input int unsigned req_pct);
      tick_item_type t;
      t.start_req  = $urandom_range(0, 99) < req_pct;
      t.mode       = 2'($urandom_range(0, 3));
      t.start_code = 8'($urandom_range(0, 255));
      t.payload    = 16'($urandom_range(0, 16'hFFFF));
      t.line_in    = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic logic line_level(input int pattern);
      if (pattern == LINE_RANDOM)
         return 1'($urandom_range(0, 1));
      return pattern == LINE_HIGH;
   endfunction

   // called on a falling edge, returns on the falling edge after the item is taken
   task automatic send_tick(input tick_item_type t);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_start_req  <= t.start_req;
      req_mode       <= t.mode;
      req_start_code <= t.start_code;
      req_payload    <= t.payload;
      req_line_in    <= t.line_in;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      tracker.take_tick(t);
      @(negedge clock);
   endtask

   // sender holds off until every owed result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (tracker.pending_levels.size() != 0);
   endtask

   task automatic set_register(input logic [CsrIndexWidth-1:0] index, input delay_type value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      tracker.write_reg(index, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // one whole frame; busy_req keeps requests coming while the frame runs
   task automatic run_frame(input logic [1:0] mode, input logic [7:0] code,
                            input logic [15:0] data, input int line_pattern,
                            input logic busy_req);
      tick_item_type t;
      // a frame left running by the last phase finishes first
      while (tracker.frame_active())
         send_tick(random_tick(0));
      t            = random_tick(0);
      t.start_req  = 1'b1;
      t.mode       = mode;
      t.start_code = code;
      t.payload    = data;
      send_tick(t);
      while (tracker.frame_active()) begin
         t           = random_tick(0);
         t.start_req = busy_req;
         t.line_in   = line_level(line_pattern);
         send_tick(t);
      end
   endtask

   task automatic random_run(input int unsigned count, input int unsigned pause_at);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == pause_at)
            drain_results();
         send_tick(random_tick(REQ_PCT));
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_start_req    = 1'b0;
      req_mode         = MODE_NINE_BIT;
      req_start_code   = '0;
      req_payload      = '0;
      req_line_in      = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_HALF_BIT;
      csr_write_data   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames at the reset delays
      // idle ticks first: reset levels must hold
      send_tick(random_tick(0));
      send_tick(random_tick(0));
      // nine-bit mode sends only bit 0 of the start byte and the low payload byte
      run_frame(MODE_NINE_BIT, 8'hFE, 16'hFFFF, LINE_RANDOM, 1'b0);
      // requests during the frame and on the done tick are dropped
      run_frame(MODE_NINE_BIT, 8'h01, 16'h0000, LINE_RANDOM, 1'b1);
      run_frame(MODE_START_BYTE, 8'h00, 16'h00FF, LINE_RANDOM, 1'b1);
      run_frame(MODE_START_WORD, 8'hA5, 16'h5AC3, LINE_RANDOM, 1'b1);
      // read frames: line held high, then held low; payload unused
      run_frame(MODE_START_READ, 8'hFF, 16'hFFFF, LINE_HIGH, 1'b0);
      run_frame(MODE_START_READ, 8'h00, 16'h0000, LINE_LOW, 1'b1);
      drain_results();

      // zero delays act as one tick, spare indexes are ignored
      set_register(CSR_HALF_BIT, 8'd0);
      set_register(CSR_FRAME_GAP, 8'd0);
      set_register(CSR_SPARE_A, 8'($urandom_range(0, 255)));
      set_register(CSR_SPARE_B, 8'($urandom_range(0, 255)));
      random_run(60, 60);
      drain_results();

      // phase may end mid frame, so new delays land inside a running frame
      set_register(CSR_HALF_BIT, 8'd2);
      set_register(CSR_FRAME_GAP, 8'd3);
      random_run(80, 40);
      drain_results();

      // slower delays, shortest frame
      set_register(CSR_HALF_BIT, 8'd4);
      set_register(CSR_FRAME_GAP, 8'd9);
      run_frame(MODE_NINE_BIT, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFFF)),
                LINE_RANDOM, 1'b1);
      drain_results();

      // fastest bits with long framing, read mode on a noisy line
      set_register(CSR_HALF_BIT, 8'd1);
      set_register(CSR_FRAME_GAP, 8'd12);
      run_frame(MODE_START_READ, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFFF)),
                LINE_RANDOM, 1'b0);
      drain_results();

      // fastest everywhere: a stretch with no idling on either side, then idling again
      set_register(CSR_FRAME_GAP, 8'd1);
      steady_flow = 1'b1;
      random_run(60, 60);
      steady_flow = 1'b0;
      random_run(60, 60);

      drain_results();
      repeat (8) @(posedge clock);
      if (tracker.pending_levels.size() != 0)
         $display("%0d results never arrived", tracker.pending_levels.size());
      if (tracker.mismatches == 0 && tracker.pending_levels.size() == 0)
         $display("PASS three_wire_serial_panel_master");
      else
         $display("FAIL three_wire_serial_panel_master");
      $finish;
   end

endmodule
